// File: hdl/smo_pkg.sv
// Package for the sliding-mode back-EMF observer: constants, register indexes and sequencer states.
`timescale 1ns / 1ps
`default_nettype none

package smo_pkg;

  // Default sample width (signed Q8.8 at 16 bits).
  localparam int unsigned SAMPLE_WIDTH = 16;

  // Fixed widths of the coefficients and intermediate values.
  localparam int unsigned COEF_WIDTH      = 16;
  localparam int unsigned GAIN_WIDTH      = 15;
  localparam int unsigned RATIO_WIDTH     = 10;
  localparam int unsigned Z_WIDTH         = 17;
  localparam int unsigned CFG_INDEX_WIDTH = 3;

  // Fixed-point shifts.
  localparam int unsigned RATIO_SHIFT = 8;
  localparam int unsigned RES_SHIFT   = 12;
  localparam int unsigned GAIN_SHIFT  = 16;

  // Limit of the clamped error ratio (1.0 in Q8.8).
  localparam int RATIO_LIMIT = 256;

  // Reset values of the configuration registers.
  localparam logic [GAIN_WIDTH-1:0] SLIDE_GAIN_RST = 15'd2560;
  localparam logic [COEF_WIDTH-1:0] BAND_RECIP_RST = 16'd256;
  localparam logic [COEF_WIDTH-1:0] STEP_OVER_L_RST = 16'd6554;
  localparam logic [COEF_WIDTH-1:0] RESISTANCE_RST = 16'd4096;
  localparam logic [COEF_WIDTH-1:0] FILTER_GAIN_RST = 16'd6554;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_SLIDE_GAIN  = 3'd0,
    CFG_BAND_RECIP  = 3'd1,
    CFG_STEP_OVER_L = 3'd2,
    CFG_RESISTANCE  = 3'd3,
    CFG_FILTER_GAIN = 3'd4
  } cfg_index_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_ERR_MUL,
    ST_RI,
    ST_RI_MUL,
    ST_Z,
    ST_Z_MUL,
    ST_DRIVE,
    ST_DRIVE_MUL,
    ST_EST,
    ST_EST_MUL,
    ST_EMF,
    ST_OUT
  } state_e;

endpackage

`default_nettype wire

// File: hdl/sliding_mode_emf_observer_top.sv
// Top level of the sliding-mode back-EMF observer with one shared multiplier.
// The block takes a new input word only in the idle state, once the last result word
// has been loaded into the output register. Each axis runs five multiplies on the
// shared multiplier (each multiply has an operand state and a product state), and the
// output state then loads the output register once it is free.
// Reset (rst_ni low, asynchronous) zeroes the estimates and restores register defaults.
`timescale 1ns / 1ps
`default_nettype none

module sliding_mode_emf_observer_top #(
  parameter int unsigned SampleWidth = smo_pkg::SAMPLE_WIDTH,
  localparam int unsigned TDataWidth = ((4 * SampleWidth + 7) / 8) * 8
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  // Configuration write channel.
  input  wire                                 cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire [smo_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index_i,
  input  wire [smo_pkg::COEF_WIDTH-1:0]       cfg_data_i,
  // Input words: volt_alpha, volt_beta, amp_alpha, amp_beta (lowest bits first).
  input  wire                                 s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  wire [TDataWidth-1:0]                s_axis_tdata_i,
  // Result words: est_amp_alpha, est_amp_beta, emf_alpha, emf_beta (lowest bits first).
  output logic                                m_axis_tvalid_o,
  input  wire                                 m_axis_tready_i,
  output logic [TDataWidth-1:0]               m_axis_tdata_o
);

  import smo_pkg::*;

  // Operand A of the shared multiplier is wide enough for the model drive term
  // volt - R*i - emf - z, which is the widest operand.
  localparam int unsigned BaseWidth = (SampleWidth + 1 > Z_WIDTH) ? SampleWidth + 1 : Z_WIDTH;
  localparam int unsigned OpWidth   = BaseWidth + 5;
  localparam int unsigned ProdWidth = OpWidth + COEF_WIDTH + 1;
  localparam int unsigned RiWidth   = SampleWidth + COEF_WIDTH - RES_SHIFT + 1;
  localparam int unsigned RfWidth   = ProdWidth - RATIO_SHIFT;

  localparam logic signed [RfWidth-1:0]     RatioMax = RfWidth'(RATIO_LIMIT);
  localparam logic signed [RfWidth-1:0]     RatioMin = -RfWidth'(RATIO_LIMIT);
  localparam logic signed [RATIO_WIDTH-1:0] RatioMaxN = RATIO_WIDTH'(RATIO_LIMIT);
  localparam logic signed [RATIO_WIDTH-1:0] RatioMinN = -RATIO_WIDTH'(RATIO_LIMIT);

  // Saturate a product-wide value to the sample range.
  function automatic logic signed [SampleWidth-1:0] sat_sample(
    input logic signed [ProdWidth-1:0] v
  );
    logic [ProdWidth-SampleWidth:0] upper;
    logic signed [SampleWidth-1:0]  res;
    upper = v[ProdWidth-1:SampleWidth-1];
    if ((&upper) || !(|upper)) begin
      res = v[SampleWidth-1:0];
    end else if (v[ProdWidth-1]) begin
      res = {1'b1, {(SampleWidth - 1){1'b0}}};
    end else begin
      res = {1'b0, {(SampleWidth - 1){1'b1}}};
    end
    return res;
  endfunction

  // Configuration registers.
  logic [GAIN_WIDTH-1:0] slide_gain_q;
  logic [COEF_WIDTH-1:0] band_recip_q;
  logic [COEF_WIDTH-1:0] step_over_l_q;
  logic [COEF_WIDTH-1:0] resistance_q;
  logic [COEF_WIDTH-1:0] filter_gain_q;

  // Sequencer.
  state_e state_q, state_d;
  logic   axis_q, axis_d;   // 0: alpha, 1: beta

  // Observer state per axis.
  logic signed [SampleWidth-1:0] est_q [2];
  logic signed [SampleWidth-1:0] est_d [2];
  logic signed [SampleWidth-1:0] emf_q [2];
  logic signed [SampleWidth-1:0] emf_d [2];

  // Latched input word.
  logic signed [SampleWidth-1:0] volt_q [2];
  logic signed [SampleWidth-1:0] volt_d [2];
  logic signed [SampleWidth-1:0] amp_q [2];
  logic signed [SampleWidth-1:0] amp_d [2];

  // Shared multiplier operands, product and intermediates.
  logic signed [OpWidth-1:0]     opa_q, opa_d;
  logic [COEF_WIDTH-1:0]         opb_q, opb_d;
  logic signed [ProdWidth-1:0]   prod_q, prod_d;
  logic signed [RATIO_WIDTH-1:0] ratio_q, ratio_d;
  logic signed [RiWidth-1:0]     ri_q, ri_d;
  logic signed [Z_WIDTH-1:0]     z_q, z_d;

  // Output register.
  logic                  out_valid_q, out_valid_d;
  logic [TDataWidth-1:0] out_data_q, out_data_d;

  logic in_accept;
  logic out_free;

  logic signed [SampleWidth-1:0] cur_est;
  logic signed [SampleWidth-1:0] cur_emf;
  logic signed [SampleWidth-1:0] cur_volt;
  logic signed [SampleWidth-1:0] cur_amp;
  logic signed [RfWidth-1:0]     ratio_full;
  logic signed [Z_WIDTH-1:0]     z_now;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  assign cur_est    = est_q[axis_q];
  assign cur_emf    = emf_q[axis_q];
  assign cur_volt   = volt_q[axis_q];
  assign cur_amp    = amp_q[axis_q];
  assign ratio_full = $signed(prod_q[ProdWidth-1:RATIO_SHIFT]);
  assign z_now      = $signed(prod_q[Z_WIDTH+RATIO_SHIFT-1:RATIO_SHIFT]);

  // Configuration writes; the user must write them only while the block is idle, as the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slide_gain_q  <= SLIDE_GAIN_RST;
      band_recip_q  <= BAND_RECIP_RST;
      step_over_l_q <= STEP_OVER_L_RST;
      resistance_q  <= RESISTANCE_RST;
      filter_gain_q <= FILTER_GAIN_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SLIDE_GAIN:  slide_gain_q  <= cfg_data_i[GAIN_WIDTH-1:0];
        CFG_BAND_RECIP:  band_recip_q  <= cfg_data_i;
        CFG_STEP_OVER_L: step_over_l_q <= cfg_data_i;
        CFG_RESISTANCE:  resistance_q  <= cfg_data_i;
        CFG_FILTER_GAIN: filter_gain_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Next state of the sequencer. Each axis walks the same five multiplies.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:      if (in_accept) state_d = ST_ERR;
      ST_ERR:       state_d = ST_ERR_MUL;
      ST_ERR_MUL:   state_d = ST_RI;
      ST_RI:        state_d = ST_RI_MUL;
      ST_RI_MUL:    state_d = ST_Z;
      ST_Z:         state_d = ST_Z_MUL;
      ST_Z_MUL:     state_d = ST_DRIVE;
      ST_DRIVE:     state_d = ST_DRIVE_MUL;
      ST_DRIVE_MUL: state_d = ST_EST;
      ST_EST:       state_d = ST_EST_MUL;
      ST_EST_MUL:   state_d = ST_EMF;
      ST_EMF:       state_d = axis_q ? ST_OUT : ST_ERR;
      ST_OUT:       if (out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // Datapath controls. The multiplier runs every cycle on the registered operands;
  // operand states load operands; each state after a product state consumes the product.
  always_comb begin
    axis_d      = axis_q;
    est_d       = est_q;
    emf_d       = emf_q;
    volt_d      = volt_q;
    amp_d       = amp_q;
    opa_d       = opa_q;
    opb_d       = opb_q;
    ratio_d     = ratio_q;
    ri_d        = ri_q;
    z_d         = z_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    prod_d      = opa_q * $signed({1'b0, opb_q});

    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          volt_d[0] = s_axis_tdata_i[SampleWidth-1:0];
          volt_d[1] = s_axis_tdata_i[2*SampleWidth-1:SampleWidth];
          amp_d[0]  = s_axis_tdata_i[3*SampleWidth-1:2*SampleWidth];
          amp_d[1]  = s_axis_tdata_i[4*SampleWidth-1:3*SampleWidth];
          axis_d    = 1'b0;
        end
      end
      ST_ERR: begin
        // Current error, estimate minus measurement, times the reciprocal band.
        opa_d = OpWidth'(cur_est) - OpWidth'(cur_amp);
        opb_d = band_recip_q;
      end
      ST_RI: begin
        if (ratio_full > RatioMax) begin
          ratio_d = RatioMaxN;
        end else if (ratio_full < RatioMin) begin
          ratio_d = RatioMinN;
        end else begin
          ratio_d = ratio_full[RATIO_WIDTH-1:0];
        end
        opa_d = OpWidth'(cur_est);
        opb_d = resistance_q;
      end
      ST_Z: begin
        ri_d  = prod_q[SampleWidth+COEF_WIDTH:RES_SHIFT];
        opa_d = OpWidth'(ratio_q);
        opb_d = COEF_WIDTH'(slide_gain_q);
      end
      ST_DRIVE: begin
        // Drive of the R-L model uses the EMF from before this step.
        z_d   = z_now;
        opa_d = OpWidth'(cur_volt) - OpWidth'(ri_q) - OpWidth'(cur_emf) - OpWidth'(z_now);
        opb_d = step_over_l_q;
      end
      ST_EST: begin
        est_d[axis_q] = sat_sample(ProdWidth'(cur_est) + (prod_q >>> GAIN_SHIFT));
        opa_d = OpWidth'(z_q) - OpWidth'(cur_emf);
        opb_d = filter_gain_q;
      end
      ST_EMF: begin
        emf_d[axis_q] = sat_sample(ProdWidth'(cur_emf) + (prod_q >>> GAIN_SHIFT));
        axis_d = 1'b1;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = TDataWidth'({emf_q[1], emf_q[0], est_q[1], est_q[0]});
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= 1'b0;
      out_valid_q <= 1'b0;
      est_q[0]    <= '0;
      est_q[1]    <= '0;
      emf_q[0]    <= '0;
      emf_q[1]    <= '0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
      est_q       <= est_d;
      emf_q       <= emf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    volt_q     <= volt_d;
    amp_q      <= amp_d;
    opa_q      <= opa_d;
    opb_q      <= opb_d;
    prod_q     <= prod_d;
    ratio_q    <= ratio_d;
    ri_q       <= ri_d;
    z_q        <= z_d;
    out_data_q <= out_data_d;
  end

  // A new result word is only ever loaded from the output state.
  a_out_from_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_OUT)
    else $error("result word loaded outside the output state");

  // Results go out only after both axes were processed.
  a_out_after_beta: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) |-> axis_q)
    else $error("output state reached before the beta axis");

  // The clamped ratio fed to the slide gain stays within plus or minus one.
  a_ratio_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_Z) |-> (ratio_q <= RatioMaxN && ratio_q >= RatioMinN))
    else $error("sliding ratio outside its clamp");

endmodule

`default_nettype wire

// File: verif/sliding_mode_emf_observer_top_tb.sv
// Self-checking testbench for the sliding-mode back-EMF observer top level.
`timescale 1ns / 1ps

// The testbench works as follows.
// The stimulus block queues input words. A clocked driver hands them to the slave stream port.
// A bit-accurate observer model predicts the result word for every accepted input word.
// A clocked monitor checks each result word against the oldest prediction, field by field.
// Register writes happen only while the observer is idle, between phases.
module sliding_mode_emf_observer_top_tb;

  import smo_pkg::*;

  localparam int SW  = SAMPLE_WIDTH;
  localparam int TDW = ((4 * SW + 7) / 8) * 8;

  // The pause is longer than the sequencer needs for one input word, so it is ample.
  localparam int SETTLE_CYCLES = 40;
  // Cycles without any handshake before the run is declared hung.
  localparam int HANG_LIMIT = 2000;

  localparam logic [SW-1:0] SAMPLE_MAX = {1'b0, {(SW - 1) {1'b1}}};
  localparam logic [SW-1:0] SAMPLE_MIN = {1'b1, {(SW - 1) {1'b0}}};
  localparam longint SAT_HI = (longint'(1) <<< (SW - 1)) - 1;
  localparam longint SAT_LO = -SAT_HI - 1;

  // How often each side idles during a phase.
  typedef enum int {
    GAPS_NONE,
    GAPS_SENDER,
    GAPS_RECEIVER,
    GAPS_BOTH
  } gap_mode_e;

  // One input word. The last field sits in the lowest bits.
  typedef struct packed {
    logic signed [SW-1:0] amp_beta;
    logic signed [SW-1:0] amp_alpha;
    logic signed [SW-1:0] volt_beta;
    logic signed [SW-1:0] volt_alpha;
  } sample_word_t;

  // One result word. The last field sits in the lowest bits.
  typedef struct packed {
    logic signed [SW-1:0] emf_beta;
    logic signed [SW-1:0] emf_alpha;
    logic signed [SW-1:0] est_amp_beta;
    logic signed [SW-1:0] est_amp_alpha;
  } estimate_word_t;

  // Every input of the block has a known value from time zero.
  logic                       clk_i           = 1'b0;
  logic                       rst_ni          = 1'b0;
  logic                       cfg_valid_i     = 1'b0;
  logic                       cfg_ready_o;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index_i     = '0;
  logic [COEF_WIDTH-1:0]      cfg_data_i      = '0;
  logic                       s_axis_tvalid_i = 1'b0;
  logic                       s_axis_tready_o;
  // Fields from the lowest bit up: volt_alpha, volt_beta, amp_alpha, amp_beta.
  logic [TDW-1:0]             s_axis_tdata_i  = '0;
  logic                       m_axis_tvalid_o;
  logic                       m_axis_tready_i = 1'b0;
  // Fields from the lowest bit up: est_amp_alpha, est_amp_beta, emf_alpha, emf_beta.
  logic [TDW-1:0]             m_axis_tdata_o;

  sliding_mode_emf_observer_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // These are the model's copies of the registers. They start at the reset values.
  longint gain_q = longint'(SLIDE_GAIN_RST);
  longint band_q = longint'(BAND_RECIP_RST);
  longint step_q = longint'(STEP_OVER_L_RST);
  longint res_q  = longint'(RESISTANCE_RST);
  longint filt_q = longint'(FILTER_GAIN_RST);

  // These are the model's copies of the observer state. They start at zero, as after reset.
  longint est_alpha = 0;
  longint est_beta  = 0;
  longint emf_alpha = 0;
  longint emf_beta  = 0;

  sample_word_t   sample_q[$];
  estimate_word_t estimate_q[$];

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int words_sent      = 0;
  int words_checked   = 0;
  int settings_run    = 0;
  int error_count     = 0;

  function automatic longint saturate(input longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  // This function advances one axis by one PWM period. All right shifts are arithmetic, so they floor.
  // The current step uses the EMF estimate from before the update.
  function automatic void advance_axis(input longint volt, input longint meas,
                                       inout longint est, inout longint emf);
    longint ratio;
    longint inj;
    longint drop;
    longint drive;
    ratio = ((est - meas) * band_q) >>> RATIO_SHIFT;
    if (ratio > RATIO_LIMIT) ratio = RATIO_LIMIT;
    if (ratio < -RATIO_LIMIT) ratio = -RATIO_LIMIT;
    inj   = (gain_q * ratio) >>> RATIO_SHIFT;
    drop  = (res_q * est) >>> RES_SHIFT;
    drive = volt - drop - emf - inj;
    est   = saturate(est + ((step_q * drive) >>> GAIN_SHIFT));
    emf   = saturate(emf + ((filt_q * (inj - emf)) >>> GAIN_SHIFT));
  endfunction

  function automatic estimate_word_t observe_sample(input sample_word_t w);
    estimate_word_t r;
    advance_axis(longint'($signed(w.volt_alpha)), longint'($signed(w.amp_alpha)),
                 est_alpha, emf_alpha);
    advance_axis(longint'($signed(w.volt_beta)), longint'($signed(w.amp_beta)),
                 est_beta, emf_beta);
    r.est_amp_alpha = est_alpha[SW-1:0];
    r.est_amp_beta  = est_beta[SW-1:0];
    r.emf_alpha     = emf_alpha[SW-1:0];
    r.emf_beta      = emf_beta[SW-1:0];
    return r;
  endfunction

  function automatic void compare_field(input string name, input logic signed [SW-1:0] exp_v,
                                        input logic signed [SW-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      error_count++;
    end
  endfunction

  // The driver presents the queued words. It holds a word until the block accepts it,
  // and it predicts the result at the edge where the word is accepted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        estimate_q.push_back(observe_sample(sample_word_t'(s_axis_tdata_i[4*SW-1:0])));
        words_sent++;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (sample_q.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= TDW'(sample_q.pop_front());
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // The monitor checks each accepted result word and drives the stalls on the master side.
  always @(posedge clk_i) begin
    estimate_word_t got;
    estimate_word_t want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = estimate_word_t'(m_axis_tdata_o[4*SW-1:0]);
        if (estimate_q.size() == 0) begin
          $display("%0t: unexpected result word, expected none, got %h", $time, got);
          error_count++;
        end else begin
          want = estimate_q.pop_front();
          compare_field("est_amp_alpha", want.est_amp_alpha, got.est_amp_alpha);
          compare_field("est_amp_beta", want.est_amp_beta, got.est_amp_beta);
          compare_field("emf_alpha", want.emf_alpha, got.emf_alpha);
          compare_field("emf_beta", want.emf_beta, got.emf_beta);
          words_checked++;
        end
      end
      m_axis_tready_i <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // The watchdog ends a run that stops making progress on every port.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < HANG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("%0t: no handshake for %0d cycles", $time, HANG_LIMIT);
    $display("sliding_mode_emf_observer_top_tb NOT OK");
    $finish;
  end

  // This task writes one register through the configuration channel.
  // The model copy changes when the block accepts the write. An unused index changes nothing.
  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [COEF_WIDTH-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_SLIDE_GAIN:  gain_q = longint'(value[GAIN_WIDTH-1:0]);
      CFG_BAND_RECIP:  band_q = longint'(value);
      CFG_STEP_OVER_L: step_q = longint'(value);
      CFG_RESISTANCE:  res_q  = longint'(value);
      CFG_FILTER_GAIN: filt_q = longint'(value);
      default: ;
    endcase
  endtask

  // This task waits until every queued word has been accepted and every result has arrived.
  // Then it waits out the pipeline, so that a stray late word would still be caught.
  task automatic wait_idle();
    while (sample_q.size() != 0 || s_axis_tvalid_i || estimate_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic push_sample(input logic [SW-1:0] va, input logic [SW-1:0] vb,
                             input logic [SW-1:0] ia, input logic [SW-1:0] ib);
    sample_word_t w;
    w.volt_alpha = va;
    w.volt_beta  = vb;
    w.amp_alpha  = ia;
    w.amp_beta   = ib;
    sample_q.push_back(w);
  endtask

  // The largest share of samples is small. Small samples keep the current error inside the sliding band.
  // The rest are medium, full-range, at the extremes of the range, zero or minus one.
  function automatic logic [SW-1:0] pick_sample();
    int unsigned kind;
    logic [SW-1:0] v;
    kind = $urandom_range(99, 0);
    if (kind < 45) begin
      v = SW'($urandom_range(1023, 0) - 512);
    end else if (kind < 65) begin
      v = SW'($urandom_range(16383, 0) - 8192);
    end else if (kind < 90) begin
      v = SW'($urandom);
    end else begin
      case ($urandom_range(3, 0))
        0: v = SAMPLE_MAX;
        1: v = SAMPLE_MIN;
        2: v = '0;
        default: v = '1;
      endcase
    end
    return v;
  endfunction

  // This task runs one phase. It waits for idle, loads all five registers, may write the unused indexes,
  // sets the idling and then queues random words for the driver.
  task automatic run_phase(input logic [COEF_WIDTH-1:0] gain, input logic [COEF_WIDTH-1:0] band,
                           input logic [COEF_WIDTH-1:0] step, input logic [COEF_WIDTH-1:0] res,
                           input logic [COEF_WIDTH-1:0] filt, input gap_mode_e mode,
                           input bit poke_unused, input int n_items);
    int k;
    wait_idle();
    write_reg(CFG_SLIDE_GAIN, gain);
    write_reg(CFG_BAND_RECIP, band);
    write_reg(CFG_STEP_OVER_L, step);
    write_reg(CFG_RESISTANCE, res);
    write_reg(CFG_FILTER_GAIN, filt);
    // Writes to indexes past the last register must leave every register unchanged.
    if (poke_unused)
      for (k = int'(CFG_FILTER_GAIN) + 1; k < (1 << CFG_INDEX_WIDTH); k++)
        write_reg(CFG_INDEX_WIDTH'(k), COEF_WIDTH'($urandom));
    case (mode)
      GAPS_SENDER:   begin sender_idle_pct = 78; recv_stall_pct = 0;  end
      GAPS_RECEIVER: begin sender_idle_pct = 0;  recv_stall_pct = 78; end
      GAPS_BOTH:     begin sender_idle_pct = 15; recv_stall_pct = 15; end
      default:       begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
    settings_run++;
    for (k = 0; k < n_items; k++)
      push_sample(pick_sample(), pick_sample(), pick_sample(), pick_sample());
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The directed words run with the reset register values and with no idling.
    // They cover the extremes of every field, opposite signs on the two axes, and
    // alternating bit patterns. Small errors keep the ratio inside the band.
    push_sample('0, '0, '0, '0);
    push_sample(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
    push_sample(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN);
    push_sample(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX);
    push_sample(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN);
    push_sample('1, '1, '1, '1);
    push_sample(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    push_sample(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
    push_sample(16'h0100, 16'hFF00, 16'h0080, 16'hFF80);
    push_sample(16'h0100, 16'hFF00, 16'h0001, 16'hFFFF);
    push_sample(16'h0040, 16'hFFC0, 16'h0000, 16'h0000);
    repeat (4) push_sample(SAMPLE_MAX, SAMPLE_MIN, '0, '0);
    repeat (4) push_sample(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN);
    push_sample('0, '0, '0, '0);
    settings_run++;

    // The first setting has every register at its largest value. The slide gain write
    // carries a 1 in its top bit, and the block must drop that bit.
    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, GAPS_NONE, 1'b0, 95);
    // Every register at zero. A zero reciprocal band also means that there is no injection.
    run_phase('0, '0, '0, '0, '0, GAPS_SENDER, 1'b1, 95);
    // The default values are written back explicitly.
    run_phase(16'd2560, 16'd256, 16'd6554, 16'd4096, 16'd6554, GAPS_RECEIVER, 1'b0, 95);
    // A zero reciprocal band with typical gains.
    run_phase(16'd8000, '0, 16'd20000, 16'd4096, 16'd30000, GAPS_BOTH, 1'b0, 95);
    // A narrow error band with a strong injection. The current step is large, so the estimates saturate.
    run_phase(16'd32767, 16'd65535, 16'd65535, 16'd1024, 16'd65535, GAPS_NONE, 1'b0, 95);
    // The widest error band allowed, with the smallest nonzero coefficients.
    run_phase(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, GAPS_SENDER, 1'b1, 95);
    run_phase(COEF_WIDTH'($urandom), COEF_WIDTH'($urandom), COEF_WIDTH'($urandom),
              COEF_WIDTH'($urandom), COEF_WIDTH'($urandom), GAPS_RECEIVER, 1'b0, 95);
    run_phase(COEF_WIDTH'($urandom), COEF_WIDTH'($urandom_range(4096, 1)),
              COEF_WIDTH'($urandom), COEF_WIDTH'($urandom), COEF_WIDTH'($urandom),
              GAPS_BOTH, 1'b0, 95);

    wait_idle();
    if (estimate_q.size() != 0) begin
      $display("%0t: %0d result words never arrived, expected %0d more, got 0",
               $time, estimate_q.size(), estimate_q.size());
      error_count++;
    end

    $display("Ran %0d input words and checked %0d result words over %0d register settings,",
             words_sent, words_checked, settings_run);
    $display("with sender gaps, receiver stalls and writes to unused register indexes.");
    if (error_count == 0) begin
      $display("sliding_mode_emf_observer_top_tb OK");
    end else begin
      $display("sliding_mode_emf_observer_top_tb NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/smo_pkg.sv
hdl/sliding_mode_emf_observer_top.sv
verif/sliding_mode_emf_observer_top_tb.sv
